[design/odq_pkg.sv]
// Shared constants and types for the ordered dither quantizer.
`default_nettype none
package odq_pkg;

  localparam int DEF_CHANNEL_BITS    = 16;
  localparam int DEF_COORD_BITS      = 16;
  localparam int DEF_MAX_MATRIX_BITS = 4;

  // Threshold fraction bits and offset width (signed, step units in Q24)
  localparam int Q_BITS      = 24;
  localparam int OFF_W       = 28;
  localparam int PIPE_STAGES = 8;

  localparam logic [20:0] NOISE_A = 21'd1125928;
  localparam logic [16:0] NOISE_B = 17'd97931;
  localparam logic [29:0] NOISE_C = 30'd888905875;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_SIZE   = 2'd1;
  localparam logic [1:0] REG_LEVELS = 2'd2;
  localparam logic [1:0] REG_AMOUNT = 2'd3;

  typedef struct packed {
    logic       mode;
    logic [2:0] side_bits;
    logic [7:0] steps;
    logic [9:0] amount;
  } cfg_t;

  typedef struct packed {
    logic [PIPE_STAGES:1] en;
    cfg_t                 cfg;
  } pipe_ctl_t;

endpackage
`default_nettype wire

[design/odq_thresh.sv]
// Threshold generator: Bayer cell or gradient noise, then signed offset.
`default_nettype none
module odq_thresh import odq_pkg::*; #(
  parameter int COORD_BITS      = DEF_COORD_BITS,
  parameter int MAX_MATRIX_BITS = DEF_MAX_MATRIX_BITS
) (
  input  wire logic                         clk,
  input  wire pipe_ctl_t                    ctl,
  input  wire logic signed [COORD_BITS-1:0] x_coord,
  input  wire logic signed [COORD_BITS-1:0] y_coord,
  output logic signed [OFF_W-1:0]           offset
);

  logic [Q_BITS-1:0]            xe, ye;
  logic [2*MAX_MATRIX_BITS-1:0] bayer_idx;
  logic [4:0]                   sh;
  logic [Q_BITS-1:0]            seed, tb;
  logic [Q_BITS-1:0]            pa, pb, tb1, f, tb2, t3;
  logic [53:0]                  cf;
  logic signed [24:0]           dv;
  logic signed [35:0]           p;

  assign xe = Q_BITS'(x_coord);
  assign ye = Q_BITS'(y_coord);

  // Interleave x^y and y coordinate bits, least significant pair first
  always_comb begin
    bayer_idx = '0;
    for (int j = 0; j < MAX_MATRIX_BITS; j++) begin
      if (j < int'(ctl.cfg.side_bits)) begin
        bayer_idx[2*j+1] = x_coord[j] ^ y_coord[j];
        bayer_idx[2*j]   = y_coord[j];
      end
    end
  end

  assign sh   = 5'd23 - {1'b0, ctl.cfg.side_bits, 1'b0};
  assign seed = Q_BITS'({bayer_idx, 1'b1});
  assign tb   = seed << sh;

  assign cf = {24'b0, NOISE_C} * {30'b0, f};
  assign dv = $signed({1'b0, t3}) - 25'sd8388608;
  assign p  = 36'(dv) * 36'($signed({1'b0, ctl.cfg.amount}));

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      pa  <= Q_BITS'(NOISE_A * xe);
      pb  <= Q_BITS'(NOISE_B * ye);
      tb1 <= tb;
    end
    if (ctl.en[2]) begin
      f   <= pa + pb;
      tb2 <= tb1;
    end
    if (ctl.en[3]) begin
      t3 <= ctl.cfg.mode ? cf[47:24] : tb2;
    end
    if (ctl.en[4]) begin
      offset <= OFF_W'(p >>> 8);
    end
  end

endmodule
`default_nettype wire

[design/odq_lane.sv]
// One colour lane: offset, clamp, round to a level, rescale.
`default_nettype none
module odq_lane import odq_pkg::*; #(
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
  input  wire logic                    clk,
  input  wire pipe_ctl_t               ctl,
  input  wire logic [CHANNEL_BITS-1:0] chan_in,
  input  wire logic signed [OFF_W-1:0] offset,
  output logic [CHANNEL_BITS-1:0]      chan_out
);

  localparam int W_W = CHANNEL_BITS + 8;
  localparam int G_W = CHANNEL_BITS + 30;
  localparam int M_W = CHANNEL_BITS + 10;
  localparam int N_W = CHANNEL_BITS + 10;
  localparam int K   = CHANNEL_BITS + 9;
  localparam int R_W = CHANNEL_BITS + 9;

  logic [R_W-1:0] rtab [256];

  // Reciprocal of twice the step count, floored
  for (genvar g = 0; g < 256; g++) begin : g_rc
    if (g == 0) begin : g_zero
      assign rtab[g] = '0;
    end else begin : g_val
      localparam longint unsigned RV = (64'd1 << K) / (2 * g);
      assign rtab[g] = R_W'(RV);
    end
  end

  logic [CHANNEL_BITS-1:0] s1, s2, s3;
  logic [W_W-1:0]          w4, lim;
  logic signed [28:0]      so;
  logic signed [G_W-1:0]   g5, h5;
  logic signed [M_W-1:0]   m5;
  logic [M_W-1:0]          mu;
  logic [7:0]              q;
  logic [N_W-1:0]          n6, n7, n8, c8, rem, num;
  logic [R_W-1:0]          r6;
  logic [N_W+R_W-1:0]      prod;
  logic [CHANNEL_BITS-1:0] e7, e8;
  logic [8:0]              d;

  assign d   = {ctl.cfg.steps, 1'b0};
  assign so  = 29'(offset) + 29'sd8388608;
  assign g5  = (G_W'(so) <<< CHANNEL_BITS) - G_W'(so);
  assign h5  = g5 >>> Q_BITS;
  assign lim = (W_W'(ctl.cfg.steps) << CHANNEL_BITS) - W_W'(ctl.cfg.steps);
  assign mu  = M_W'(m5);

  // Clamp to [0, steps]; below the top, divide by the all-ones channel maximum
  always_comb begin
    if (m5[M_W-1]) begin
      q = '0;
    end else if (mu >= M_W'(lim)) begin
      q = ctl.cfg.steps;
    end else begin
      q = 8'((mu + (mu >> CHANNEL_BITS) + M_W'(1)) >> CHANNEL_BITS);
    end
  end

  assign num  = (N_W'(q) << (CHANNEL_BITS + 1)) - (N_W'(q) << 1) + N_W'(ctl.cfg.steps);
  assign prod = (N_W+R_W)'(n6) * (N_W+R_W)'(r6);
  assign rem  = n8 - c8;

  // Estimate is at most one low; correct it
  assign chan_out = (rem >= N_W'(d)) ? e8 + CHANNEL_BITS'(1) : e8;

  always_ff @(posedge clk) begin
    if (ctl.en[1]) s1 <= chan_in;
    if (ctl.en[2]) s2 <= s1;
    if (ctl.en[3]) s3 <= s2;
    if (ctl.en[4]) w4 <= W_W'(s3) * W_W'(ctl.cfg.steps);
    if (ctl.en[5]) m5 <= M_W'(h5) + M_W'($signed({1'b0, w4}));
    if (ctl.en[6]) begin
      n6 <= num;
      r6 <= rtab[ctl.cfg.steps];
    end
    if (ctl.en[7]) begin
      e7 <= CHANNEL_BITS'(prod >> K);
      n7 <= n6;
    end
    if (ctl.en[8]) begin
      c8 <= N_W'(N_W'(e7) * N_W'(d));
      e8 <= e7;
      n8 <= n7;
    end
  end

endmodule
`default_nettype wire

[design/ordered_dither_quantizer_core.sv]
// Pixels pass through a nine-stage pipeline whose last stage is the output register.
// Throughput: one pixel per clock while the output is not stalled; the pipeline and
// three parallel colour lanes set this.
// Stalled results hold in the output register while upstream bubbles collapse.
// Reset (rst, synchronous, active high) empties the pipeline and restores
// registers: Bayer mode, 4x4 matrix, two levels, amount of one step.
`default_nettype none
module ordered_dither_quantizer_core import odq_pkg::*; #(
  parameter int CHANNEL_BITS    = DEF_CHANNEL_BITS,
  parameter int COORD_BITS      = DEF_COORD_BITS,
  parameter int MAX_MATRIX_BITS = DEF_MAX_MATRIX_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Pixel input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] x_coord,
  input  wire logic signed [COORD_BITS-1:0] y_coord,
  input  wire logic [CHANNEL_BITS-1:0]      red_in,
  input  wire logic [CHANNEL_BITS-1:0]      green_in,
  input  wire logic [CHANNEL_BITS-1:0]      blue_in,
  input  wire logic [CHANNEL_BITS-1:0]      alpha_in,
  // Pixel output channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [CHANNEL_BITS-1:0]           red_out,
  output logic [CHANNEL_BITS-1:0]           green_out,
  output logic [CHANNEL_BITS-1:0]           blue_out,
  output logic [CHANNEL_BITS-1:0]           alpha_out,
  // Register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [3:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int LAST = PIPE_STAGES + 1;
  localparam logic [4:0] SIZE_TOP = 5'(1 << MAX_MATRIX_BITS);

  // Registers
  logic       dither_mode;
  logic [4:0] matrix_size;
  logic [8:0] level_count;
  logic [9:0] dither_amount;

  logic [LAST:1]           v;
  logic [LAST:1]           en;
  logic [4:0]              size_c;
  cfg_t                    cfg;
  pipe_ctl_t               ctl;
  logic signed [OFF_W-1:0] offset;
  logic [CHANNEL_BITS-1:0] red_l, green_l, blue_l;
  logic [CHANNEL_BITS-1:0] apipe [1:PIPE_STAGES];

  assign pready = 1'b1;

  // Register writes complete in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      dither_mode   <= 1'b0;
      matrix_size   <= 5'd4;
      level_count   <= 9'd2;
      dither_amount <= 10'd256;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MODE:   dither_mode   <= pwdata[0];
        REG_SIZE:   matrix_size   <= pwdata[4:0];
        REG_LEVELS: level_count   <= pwdata[8:0];
        REG_AMOUNT: dither_amount <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:   prdata = 32'(dither_mode);
      REG_SIZE:   prdata = 32'(matrix_size);
      REG_LEVELS: prdata = 32'(level_count);
      REG_AMOUNT: prdata = 32'(dither_amount);
      default:    prdata = '0;
    endcase
  end

  // Clamp the matrix side and floor it to a power of two
  always_comb begin
    if (matrix_size < 5'd2) begin
      size_c = 5'd2;
    end else if (matrix_size > SIZE_TOP) begin
      size_c = SIZE_TOP;
    end else begin
      size_c = matrix_size;
    end
    cfg.side_bits = 3'd1;
    for (int i = 2; i <= MAX_MATRIX_BITS; i++) begin
      if (6'(1 << i) <= {1'b0, size_c}) cfg.side_bits = 3'(i);
    end
    // Clamp the level count to 2..256 and hold steps = levels - 1
    if (level_count < 9'd2) begin
      cfg.steps = 8'd1;
    end else if (level_count > 9'd256) begin
      cfg.steps = 8'd255;
    end else begin
      cfg.steps = 8'(level_count - 9'd1);
    end
    cfg.mode   = dither_mode;
    cfg.amount = dither_amount;
  end

  // A stage advances when empty or when the stage after it advances;
  // the output register advances when empty or not stalled.
  always_comb begin
    en[LAST] = !v[LAST] || !out_stall;
    for (int k = LAST - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int k = 2; k <= LAST; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign ctl.en  = en[PIPE_STAGES:1];
  assign ctl.cfg = cfg;

  odq_thresh #(
    .COORD_BITS      (COORD_BITS),
    .MAX_MATRIX_BITS (MAX_MATRIX_BITS)
  ) u_thresh (
    .clk     (clk),
    .ctl     (ctl),
    .x_coord (x_coord),
    .y_coord (y_coord),
    .offset  (offset)
  );

  odq_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_red (
    .clk (clk), .ctl (ctl), .chan_in (red_in), .offset (offset), .chan_out (red_l)
  );

  odq_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_green (
    .clk (clk), .ctl (ctl), .chan_in (green_in), .offset (offset), .chan_out (green_l)
  );

  odq_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_blue (
    .clk (clk), .ctl (ctl), .chan_in (blue_in), .offset (offset), .chan_out (blue_l)
  );

  // Carry alpha alongside the lanes
  always_ff @(posedge clk) begin
    if (en[1]) apipe[1] <= alpha_in;
    for (int k = 2; k <= PIPE_STAGES; k++) begin
      if (en[k]) apipe[k] <= apipe[k-1];
    end
  end

  // Merge the lane results and alpha into the output register
  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      red_out   <= red_l;
      green_out <= green_l;
      blue_out  <= blue_l;
      alpha_out <= apipe[PIPE_STAGES];
    end
  end

endmodule
`default_nettype wire

[design/odq_checker.sv]
// Port-level checks for the ordered dither quantizer, bound to the top level.
`default_nettype none
module odq_port_props import odq_pkg::*; #(
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [CHANNEL_BITS-1:0] red_out,
  input wire logic                    psel,
  input wire logic                    penable,
  input wire logic                    pwrite,
  input wire logic [3:0]              paddr,
  input wire logic [31:0]             pwdata,
  input wire logic [31:0]             prdata
);

  // Drop all results on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red_out))
    else $error("stalled result changed");

  // Input backs up only when the output side is full and stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // A mode write reads back at once
  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[3:2] == REG_MODE)
    ##1 (psel && !pwrite && paddr[3:2] == REG_MODE)
    |-> prdata[0] == $past(pwdata[0]))
    else $error("mode register read back wrong");

endmodule

bind ordered_dither_quantizer_core odq_port_props #(.CHANNEL_BITS(CHANNEL_BITS)) u_odq_props (.*);
`default_nettype wire
